// ===== hdl/bounded_integer_set_unit_assert.svh =====
// ----------------------------------------------------------------------------
// bounded_integer_set_unit_assert
// assertion macros for the bounded integer set, clocked on clk, off in rst
// ----------------------------------------------------------------------------
`ifndef BOUNDED_INTEGER_SET_UNIT_ASSERT_SVH
`define BOUNDED_INTEGER_SET_UNIT_ASSERT_SVH

// same-cycle implication
`define BIS_ASSERT_IMP(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error(msg);

// next-cycle implication
`define BIS_ASSERT_NXT(label, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error(msg);

`endif

// ===== hdl/bis_pkg.sv =====
// ----------------------------------------------------------------------------
// bis_pkg
// shared types, codes and defaults of the bounded integer set
// ----------------------------------------------------------------------------
`default_nettype none

package bis_pkg;

  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 16;
  localparam int FUNC_W          = 2;
  localparam int STATUS_W        = 3;
  localparam int CFG_IDX_W       = 1;

  // operation codes
  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FN_TEST   = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 1'd1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 3'd0,
    ST_RANGE   = 3'd1,
    ST_PRESENT = 3'd2,
    ST_ABSENT  = 3'd3,
    ST_FULL    = 3'd4
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic match;
    logic decide;
    logic shift;
    logic finish_shift;
    logic minmax;
    logic publish;
  } bis_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic del_go;
    logic out_free;
  } bis_stat_t;

endpackage

`default_nettype wire

// ===== hdl/bounded_integer_set_unit.sv =====
// ----------------------------------------------------------------------------
// bounded_integer_set_unit
// set of distinct signed integers, inserted within a configured range
// ----------------------------------------------------------------------------
// One request inserts, deletes or tests one value and returns one result with
// status, prior membership, member count, least and greatest member and an
// empty flag. Requests are taken one at a time, each served in passes over
// the single read port of the member memory: one pass to search, one to
// close the gap on delete, one for min/max. The next request is taken while
// the last result still waits. The memory needs no clearing after reset.
// Range registers must be written only while the unit is idle; the unit
// itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_integer_set_unit_assert.svh"

module bounded_integer_set_unit #(
  parameter int CAPACITY    = bis_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bis_pkg::VALUE_WIDTH_DEF,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [bis_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [VALUE_WIDTH-1:0]        cfg_data,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [bis_pkg::FUNC_W-1:0]    func,
  input  wire logic signed [VALUE_WIDTH-1:0] value,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [bis_pkg::STATUS_W-1:0]       status,
  output logic                               was_present,
  output logic [CW-1:0]                      member_count,
  output logic signed [VALUE_WIDTH-1:0]      smallest,
  output logic signed [VALUE_WIDTH-1:0]      largest,
  output logic                               set_empty
);
  import bis_pkg::*;

  // commands down, status up
  bis_cmd_t  cmd;
  bis_stat_t stat;

  // sequencer
  bis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // storage, scan pointer, decision and result register
  bis_dp #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .func         (func),
    .value        (value),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .was_present  (was_present),
    .member_count (member_count),
    .smallest     (smallest),
    .largest      (largest),
    .set_empty    (set_empty)
  );

  // one request in flight at a time
  `BIS_ASSERT_NXT(a_one_in_flight, in_valid && !in_stall, in_stall, "second request taken")
  // count never passes capacity
  `BIS_ASSERT_IMP(a_count_bound, out_valid, member_count <= CW'(CAPACITY), "count over capacity")
  // a nonempty set has ordered extremes
  `BIS_ASSERT_IMP(a_min_le_max, out_valid && !set_empty, smallest <= largest, "min above max")
  // a result is only loaded into a free output register
  `BIS_ASSERT_IMP(a_no_overwrite, cmd.publish, !out_valid || !out_stall, "result lost")

endmodule

`default_nettype wire

// ===== hdl/bis_ctrl.sv =====
// ----------------------------------------------------------------------------
// bis_ctrl
// sequencer: search pass, decision, compaction pass, min/max pass, result
// ----------------------------------------------------------------------------
`default_nettype none

module bis_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bis_pkg::bis_stat_t stat,
  output bis_pkg::bis_cmd_t      cmd
);
  import bis_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SRCH   = 6'b000010,
    S_DECIDE = 6'b000100,
    S_SHIFT  = 6'b001000,
    S_MINMAX = 6'b010000,
    S_RESULT = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SRCH;
        end
      end
      S_SRCH: begin
        cmd.scan  = 1'b1;
        cmd.match = 1'b1;
        if (stat.scan_done) state_next = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = stat.del_go ? S_SHIFT : S_MINMAX;
      end
      S_SHIFT: begin
        cmd.scan  = 1'b1;
        cmd.shift = 1'b1;
        if (stat.scan_done) begin
          cmd.finish_shift = 1'b1;
          state_next       = S_MINMAX;
        end
      end
      S_MINMAX: begin
        cmd.scan   = 1'b1;
        cmd.minmax = 1'b1;
        if (stat.scan_done) state_next = S_RESULT;
      end
      S_RESULT: begin
        if (stat.out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

endmodule

`default_nettype wire

// ===== hdl/bis_dp.sv =====
// ----------------------------------------------------------------------------
// bis_dp
// range registers, member memory, scan pointer, decision logic, result register
// ----------------------------------------------------------------------------
`default_nettype none

module bis_dp #(
  parameter int CAPACITY    = bis_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = bis_pkg::VALUE_WIDTH_DEF,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [bis_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [VALUE_WIDTH-1:0]              cfg_data,
  input  wire logic [bis_pkg::FUNC_W-1:0]          func,
  input  wire logic signed [VALUE_WIDTH-1:0]       value,
  input  wire bis_pkg::bis_cmd_t                   cmd,
  output bis_pkg::bis_stat_t                       stat,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [bis_pkg::STATUS_W-1:0]             status,
  output logic                                     was_present,
  output logic [CW-1:0]                            member_count,
  output logic signed [VALUE_WIDTH-1:0]            smallest,
  output logic signed [VALUE_WIDTH-1:0]            largest,
  output logic                                     set_empty
);
  import bis_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic signed [VALUE_WIDTH-1:0] range_a, range_b;
  logic [FUNC_W-1:0]             op_func;
  logic signed [VALUE_WIDTH-1:0] op_value;
  logic [CW-1:0]                 cnt;
  logic [CW-1:0]                 ptr;
  logic                          rvalid;
  logic [AW-1:0]                 ridx;
  logic signed [VALUE_WIDTH-1:0] rdata;
  logic                          found;
  logic [AW-1:0]                 pos;
  status_t                       res_status;
  logic                          res_present;
  logic signed [VALUE_WIDTH-1:0] mn, mx;
  logic signed [VALUE_WIDTH-1:0] mem [CAPACITY];

  logic                          rd_go;
  logic                          hit;
  logic                          wen;
  logic [AW-1:0]                 waddr;
  logic signed [VALUE_WIDTH-1:0] wdata;
  logic signed [VALUE_WIDTH-1:0] lo, hi;
  logic                          in_range;
  logic                          full;
  status_t                       dec_status;
  logic                          ins_go, del_go;

  // range registers
  always_ff @(posedge clk) begin
    if (rst) begin
      range_a <= {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      range_b <= {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    end else if (cfg_we) begin
      if (cfg_index == REG_RANGE_LOW) range_a <= cfg_data;
      else                            range_b <= cfg_data;
    end
  end

  // decision
  assign lo       = (range_a <= range_b) ? range_a : range_b;
  assign hi       = (range_a <= range_b) ? range_b : range_a;
  assign in_range = (op_value >= lo) && (op_value <= hi);
  assign full     = (cnt >= CW'(CAPACITY));

  always_comb begin
    dec_status = ST_DONE;
    ins_go     = 1'b0;
    del_go     = 1'b0;
    unique case (op_func)
      FN_INSERT: begin
        if (!in_range)  dec_status = ST_RANGE;
        else if (found) dec_status = ST_PRESENT;
        else if (full)  dec_status = ST_FULL;
        else            ins_go     = 1'b1;
      end
      FN_DELETE: begin
        if (!found)         dec_status = ST_ABSENT;
        else if (!in_range) dec_status = ST_RANGE;
        else                del_go     = 1'b1;
      end
      default: dec_status = found ? ST_DONE : ST_ABSENT;
    endcase
  end

  // member memory, one write and one registered read per cycle
  assign rd_go = cmd.scan && (ptr < cnt);
  assign hit   = rvalid && (rdata == op_value);
  assign wen   = (cmd.decide && ins_go) || (cmd.shift && rvalid);
  assign waddr = cmd.shift ? (ridx - 1'b1) : cnt[AW-1:0];
  assign wdata = cmd.shift ? rdata : op_value;

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata <= mem[ptr[AW-1:0]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      ptr       <= '0;
      rvalid    <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rvalid <= rd_go;
      if (cmd.load || cmd.finish_shift) ptr <= '0;
      else if (cmd.decide)              ptr <= del_go ? (CW'(pos) + 1'b1) : '0;
      else if (rd_go)                   ptr <= ptr + 1'b1;
      if (cmd.decide && ins_go) cnt <= cnt + 1'b1;
      else if (cmd.finish_shift) cnt <= cnt - 1'b1;
      if (cmd.load)                 found <= 1'b0;
      else if (cmd.match && hit)    found <= 1'b1;
      if (cmd.publish)              out_valid <= 1'b1;
      else if (!out_stall)          out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ridx <= ptr[AW-1:0];
    if (cmd.load) begin
      op_func  <= func;
      op_value <= value;
    end
    if (cmd.match && hit && !found) pos <= ridx;
    if (cmd.decide) begin
      res_status  <= dec_status;
      res_present <= found;
    end
    if (cmd.decide || cmd.finish_shift) begin
      mn <= '0;
      mx <= '0;
    end else if (cmd.minmax && rvalid) begin
      if (ridx == '0) begin
        mn <= rdata;
        mx <= rdata;
      end else begin
        if (rdata < mn) mn <= rdata;
        if (rdata > mx) mx <= rdata;
      end
    end
    if (cmd.publish) begin
      status       <= res_status;
      was_present  <= res_present;
      member_count <= cnt;
      smallest     <= mn;
      largest      <= mx;
      set_empty    <= (cnt == '0);
    end
  end

  assign stat.scan_done = (ptr >= cnt) && !rvalid;
  assign stat.del_go    = del_go;
  assign stat.out_free  = !out_valid || !out_stall;

endmodule

`default_nettype wire

// ===== bench/bounded_integer_set_unit_test.sv =====
// ----------------------------------------------------------------------------
// bounded_integer_set_unit_test
// self-checking bench for the bounded integer set
// ----------------------------------------------------------------------------
// A scoreboard keeps its own copy of the member list and both range registers,
// works out the outcome of every accepted request and checks each result
// field by field in order. A short directed run covers the corner cases, then
// random phases fill, grow, shrink and churn the set under changing ranges,
// with random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module bounded_integer_set_unit_test;
  import bis_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int VW  = VALUE_WIDTH_DEF;
  localparam int CW  = $clog2(CAP + 1);

  // the spare operation code, which the unit treats as a membership test
  localparam logic [FUNC_W-1:0] FN_SPARE = 2'd3;

  localparam int RANDOM_REQUESTS = 1700;
  localparam int DRAIN_CYCLES    = 300;
  localparam int WATCHDOG        = 8_000_000;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED, PH_FILL} phase_kind_t;

  typedef struct {
    status_t              status;
    logic                 was_present;
    logic [CW-1:0]        member_count;
    logic signed [VW-1:0] smallest;
    logic signed [VW-1:0] largest;
    logic                 set_empty;
  } outcome_t;

  // scoreboard: mirrors the member list and range registers, queues the
  // outcome of each accepted request and checks results against it
  class set_scoreboard;
    logic signed [VW-1:0] members [CAP];
    int                   member_total;
    logic signed [VW-1:0] bound_a;
    logic signed [VW-1:0] bound_b;
    outcome_t             expected_q [$];
    int                   failures;
    int                   checked;
    int                   status_hits [5];

    function new();
      member_total = 0;
      bound_a      = 16'sh8000;
      bound_b      = 16'sh7fff;
      failures     = 0;
      checked      = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void set_bound(logic [CFG_IDX_W-1:0] idx, logic [VW-1:0] data);
      if (idx == REG_RANGE_LOW) begin
        bound_a = data;
      end else begin
        bound_b = data;
      end
    endfunction

    function int low_bound();
      return (bound_a <= bound_b) ? bound_a : bound_b;
    endfunction

    function int high_bound();
      return (bound_a <= bound_b) ? bound_b : bound_a;
    endfunction

    function int pending_count();
      return expected_q.size();
    endfunction

    function void note_request(logic [FUNC_W-1:0] fn, logic signed [VW-1:0] v);
      outcome_t o;
      int       pos;
      bit       fits;
      pos = -1;
      for (int i = 0; i < member_total; i++) begin
        if (members[i] == v) pos = i;
      end
      fits          = (v >= low_bound()) && (v <= high_bound());
      o.was_present = (pos >= 0);
      if (fn == FN_INSERT) begin
        // range first, then presence, then room
        if (!fits) begin
          o.status = ST_RANGE;
        end else if (pos >= 0) begin
          o.status = ST_PRESENT;
        end else if (member_total >= CAP) begin
          o.status = ST_FULL;
        end else begin
          members[member_total] = v;
          member_total++;
          o.status = ST_DONE;
        end
      end else if (fn == FN_DELETE) begin
        // presence first, then range
        if (pos < 0) begin
          o.status = ST_ABSENT;
        end else if (!fits) begin
          o.status = ST_RANGE;
        end else begin
          for (int i = pos; i < member_total - 1; i++) members[i] = members[i + 1];
          member_total--;
          o.status = ST_DONE;
        end
      end else if (pos >= 0) begin
        o.status = ST_DONE;
      end else begin
        o.status = ST_ABSENT;
      end
      o.smallest = '0;
      o.largest  = '0;
      for (int i = 0; i < member_total; i++) begin
        if (i == 0 || members[i] < o.smallest) o.smallest = members[i];
        if (i == 0 || members[i] > o.largest) o.largest = members[i];
      end
      o.member_count = CW'(member_total);
      o.set_empty    = (member_total == 0);
      status_hits[o.status]++;
      expected_q.push_back(o);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic wp, logic [CW-1:0] cnt,
                               logic signed [VW-1:0] sm, logic signed [VW-1:0] lg,
                               logic emp);
      outcome_t o;
      if (expected_q.size() == 0) begin
        failures++;
        $error("result arrived with no request outstanding");
        return;
      end
      o = expected_q.pop_front();
      checked++;
      if (st !== o.status) begin
        failures++;
        $error("status: expected %0d, got %0d", o.status, st);
      end
      if (wp !== o.was_present) begin
        failures++;
        $error("was_present: expected %0d, got %0d", o.was_present, wp);
      end
      if (cnt !== o.member_count) begin
        failures++;
        $error("member_count: expected %0d, got %0d", o.member_count, cnt);
      end
      if (sm !== o.smallest) begin
        failures++;
        $error("smallest: expected %0d, got %0d", o.smallest, sm);
      end
      if (lg !== o.largest) begin
        failures++;
        $error("largest: expected %0d, got %0d", o.largest, lg);
      end
      if (emp !== o.set_empty) begin
        failures++;
        $error("set_empty: expected %0d, got %0d", o.set_empty, emp);
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // signals; every input of the unit starts at a known value
  // ---------------------------------------------------------------------------
  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [VW-1:0]        cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [FUNC_W-1:0]    func = FN_TEST;
  logic signed [VW-1:0] value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic                 was_present;
  logic [CW-1:0]        member_count;
  logic signed [VW-1:0] smallest;
  logic signed [VW-1:0] largest;
  logic                 set_empty;

  set_scoreboard        sb;
  logic signed [VW-1:0] recent_values [$];   // values used lately, for repeats
  int                   gap_max = 10;        // request side idle limit
  int                   stall_max = 10;      // result side stall limit
  int                   stall_left = 0;
  int                   requests_sent = 0;
  int                   range_settings = 0;

  bounded_integer_set_unit #(
    .CAPACITY    (CAP),
    .VALUE_WIDTH (VW)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .was_present  (was_present),
    .member_count (member_count),
    .smallest     (smallest),
    .largest      (largest),
    .set_empty    (set_empty)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog, sized from the slowest legal run several times over
  initial begin
    #(WATCHDOG);
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result side: check each accepted result, then draw the next stall length;
  // the stall counts down whether or not a result is waiting
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_result(status, was_present, member_count, smallest, largest, set_empty);
        stall_left = $urandom_range(0, stall_max);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left > 0);
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // one request: optional idle gap, then hold until the unit takes it
  task automatic send_request(input logic [FUNC_W-1:0] fn, input logic signed [VW-1:0] v);
    int gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= fn;
    value    <= v;
    do @(posedge clk); while (in_stall);
    sb.note_request(fn, v);
    requests_sent++;
  endtask

  // stop sending and wait until every outstanding result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_count() != 0);
  endtask

  // register write, only ever issued with the unit idle
  task automatic write_bound(input logic [CFG_IDX_W-1:0] idx, input logic [VW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_bound(idx, data);
    range_settings++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // new range for a phase: full, swapped full, single points, one bound moved, random pairs
  task automatic pick_range();
    logic [VW-1:0] p;
    p = VW'($urandom_range(0, 16'hffff));
    case ($urandom_range(0, 7))
      0: begin
        write_bound(REG_RANGE_LOW, 16'h8000);
        write_bound(REG_RANGE_HIGH, 16'h7fff);
      end
      1: begin
        write_bound(REG_RANGE_LOW, 16'h7fff);
        write_bound(REG_RANGE_HIGH, 16'h8000);
      end
      2: begin
        write_bound(REG_RANGE_LOW, p);
        write_bound(REG_RANGE_HIGH, p);
      end
      3: begin
        write_bound(REG_RANGE_LOW, 16'h8000);
        write_bound(REG_RANGE_HIGH, 16'h8000);
      end
      4: begin
        write_bound(REG_RANGE_LOW, 16'h7fff);
        write_bound(REG_RANGE_HIGH, 16'h7fff);
      end
      5: write_bound(REG_RANGE_LOW, p);    // move one bound only
      6: write_bound(REG_RANGE_HIGH, p);
      default: begin
        write_bound(REG_RANGE_LOW, p);
        write_bound(REG_RANGE_HIGH, VW'($urandom_range(0, 16'hffff)));
      end
    endcase
  endtask

  // operand: mostly members, range edges, fresh in-range values and repeats, some noise
  function automatic logic signed [VW-1:0] choose_value(input logic [FUNC_W-1:0] fn);
    int                   r;
    int                   lo;
    int                   hi;
    logic signed [VW-1:0] v;
    r  = $urandom_range(0, 99);
    lo = sb.low_bound();
    hi = sb.high_bound();
    if (r < 15) return VW'($urandom_range(0, 16'hffff));
    if (r < 25) begin
      // just inside and just outside the bounds
      case ($urandom_range(0, 3))
        0: return VW'(lo);
        1: return VW'(hi);
        2: return VW'(lo - 1);
        default: return VW'(hi + 1);
      endcase
    end
    if (fn != FN_INSERT && sb.member_total > 0 && r < 70)
      return sb.members[$urandom_range(0, sb.member_total - 1)];
    if ((fn == FN_INSERT && r < 70) || recent_values.size() == 0) begin
      v = VW'(lo + $urandom_range(0, hi - lo));
      recent_values.push_back(v);
      if (recent_values.size() > 200) void'(recent_values.pop_front());
      return v;
    end
    return recent_values[$urandom_range(0, recent_values.size() - 1)];
  endfunction

  // operation mix per phase kind; the spare code shows up now and then
  function automatic logic [FUNC_W-1:0] choose_op(input phase_kind_t kind);
    int r;
    int ins_pct;
    int del_pct;
    r = $urandom_range(0, 99);
    case (kind)
      PH_GROW:   begin ins_pct = 70; del_pct = 15; end
      PH_SHRINK: begin ins_pct = 15; del_pct = 65; end
      default:   begin ins_pct = 40; del_pct = 35; end
    endcase
    if (r < ins_pct) return FN_INSERT;
    if (r < ins_pct + del_pct) return FN_DELETE;
    if (r >= 97) return FN_SPARE;
    return FN_TEST;
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    phase_kind_t kind;
    int          random_done;
    int          phase_no;
    int          len;
    logic [FUNC_W-1:0] fn;

    sb = new();
    random_done = 0;
    phase_no    = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty set, extremes, duplicates, spare code, delete of absent
    send_request(FN_TEST, 16'sd0);
    send_request(FN_DELETE, 16'sd5);
    send_request(FN_INSERT, 16'sh8000);
    send_request(FN_INSERT, 16'sh7fff);
    send_request(FN_INSERT, 16'sd0);
    send_request(FN_INSERT, 16'sd0);
    send_request(FN_TEST, 16'sh7fff);
    send_request(FN_SPARE, 16'sd0);
    send_request(FN_SPARE, 16'sd1);
    send_request(FN_DELETE, 16'sd0);
    send_request(FN_DELETE, 16'sd0);

    // reversed bounds; members left outside the new range cannot be deleted
    drain();
    write_bound(REG_RANGE_LOW, 16'sd100);
    write_bound(REG_RANGE_HIGH, -16'sd100);
    send_request(FN_INSERT, 16'sd101);
    send_request(FN_INSERT, -16'sd101);
    send_request(FN_INSERT, -16'sd100);
    send_request(FN_INSERT, 16'sd100);
    send_request(FN_DELETE, 16'sh7fff);
    send_request(FN_DELETE, 16'sh8000);
    send_request(FN_TEST, 16'sh8000);
    // present but out of range: range wins
    send_request(FN_INSERT, 16'sh7fff);

    // single-value range
    drain();
    write_bound(REG_RANGE_LOW, 16'sd7);
    write_bound(REG_RANGE_HIGH, 16'sd7);
    send_request(FN_INSERT, 16'sd7);
    send_request(FN_INSERT, 16'sd8);
    send_request(FN_INSERT, 16'sd6);

    // random phases; every sixth one fills the set to capacity and beyond
    while (random_done < RANDOM_REQUESTS) begin
      drain();
      if (phase_no % 6 == 0) begin
        kind = PH_FILL;
      end else begin
        case ($urandom_range(0, 2))
          0: kind = PH_GROW;
          1: kind = PH_SHRINK;
          default: kind = PH_MIXED;
        endcase
      end
      // each side, drawn on its own, runs with no idling in about a quarter of the phases
      gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 10;
      stall_max = ($urandom_range(0, 3) == 0) ? 0 : 10;

      if (kind == PH_FILL) begin
        if ($urandom_range(0, 1) == 0) begin
          write_bound(REG_RANGE_LOW, 16'h8000);
          write_bound(REG_RANGE_HIGH, 16'h7fff);
        end else begin
          write_bound(REG_RANGE_LOW, 16'h7fff);
          write_bound(REG_RANGE_HIGH, 16'h8000);
        end
        while (sb.member_total < CAP) begin
          send_request(FN_INSERT, VW'($urandom_range(0, 16'hffff)));
          random_done++;
        end
        // inserts into a full set, then look-ups of members and strangers
        repeat (4) begin
          send_request(FN_INSERT, VW'($urandom_range(0, 16'hffff)));
          random_done++;
        end
        repeat (4) begin
          send_request(FN_TEST, choose_value(FN_TEST));
          random_done++;
        end
      end else begin
        pick_range();
        len = $urandom_range(60, 140);
        repeat (len) begin
          // now and then let everything drain before the next request
          if ($urandom_range(0, 39) == 0) drain();
          fn = choose_op(kind);
          send_request(fn, choose_value(fn));
          random_done++;
        end
      end
      phase_no++;
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests in %0d phases with %0d register writes, %0d results checked",
             requests_sent, phase_no, range_settings, sb.checked);
    $display("outcomes: done %0d, out of range %0d, already present %0d, not present %0d, full %0d",
             sb.status_hits[ST_DONE], sb.status_hits[ST_RANGE], sb.status_hits[ST_PRESENT],
             sb.status_hits[ST_ABSENT], sb.status_hits[ST_FULL]);
    if (sb.failures == 0 && sb.pending_count() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
